[rtl/dmxr_pkg.sv]
// Shared types and constants for the DMX512 frame receiver.
`timescale 1ns / 1ps
package dmxr_pkg;

  // Window size and derived widths
  localparam int MAX_CHANNELS = 32;
  localparam int CH_IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_CNT_W     = 6;
  localparam int SLOT_W       = 10;
  localparam int ADDR_W       = 9;
  localparam int CFG_IDX_W    = 3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(512);

  // Register reset values
  localparam logic [31:0]         BREAK_MIN_RST     = 32'd8;
  localparam logic [31:0]         BREAK_MAX_RST     = 32'd1000;
  localparam logic [7:0]          TIMEOUT_RST       = 8'd100;
  localparam logic [ADDR_W-1:0]   START_ADDR_RST    = '0;
  localparam logic [CH_CNT_W-1:0] CHANNEL_COUNT_RST = CH_CNT_W'(32);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  // Input item opcodes
  typedef enum logic [1:0] {
    OP_FALL = 2'd0,
    OP_RISE = 2'd1,
    OP_BYTE = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic rd_clear;  // restart window readout at entry 0
    logic rd_load;   // read window entry into output register
    logic rd_step;   // advance to next window entry
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_req;  // current item ends a frame that must be emitted
    logic rd_last;   // output register holds the final channel
  } dp_stat_t;

endpackage

[rtl/dmxr_ctrl.sv]
// Controller state machine: item intake and window readout sequencing.
`timescale 1ns / 1ps
module dmxr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dmxr_pkg::dp_stat_t  stat,
  output dmxr_pkg::ctrl_cmd_t cmd
);

  dmxr_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmxr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dmxr_pkg::S_IDLE: begin
        if (in_valid && stat.emit_req) state_next = dmxr_pkg::S_READ;
      end
      dmxr_pkg::S_READ: begin
        state_next = dmxr_pkg::S_SHOW;
      end
      dmxr_pkg::S_SHOW: begin
        if (out_ready) begin
          state_next = stat.rd_last ? dmxr_pkg::S_IDLE : dmxr_pkg::S_READ;
        end
      end
      default: state_next = dmxr_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      dmxr_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.accept   = in_valid;
        cmd.rd_clear = in_valid && stat.emit_req;
      end
      dmxr_pkg::S_READ: begin
        cmd.rd_load = 1'b1;
      end
      dmxr_pkg::S_SHOW: begin
        out_valid   = 1'b1;
        cmd.rd_step = out_ready && !stat.rd_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/dmxr_dp.sv]
// Datapath: config registers, break detection, slot counting, window store.
`timescale 1ns / 1ps
module dmxr_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  dmxr_pkg::ctrl_cmd_t                cmd,
  output dmxr_pkg::dp_stat_t                 stat,
  input  logic                               cfg_valid,
  input  logic [dmxr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic [1:0]                         op,
  input  logic [31:0]                        timestamp,
  input  logic [7:0]                         data_byte,
  output logic [7:0]                         channel_value,
  output logic [4:0]                         channel_index,
  output logic                               last
);

  localparam int IW = dmxr_pkg::CH_IDX_W;
  localparam int CW = dmxr_pkg::CH_CNT_W;
  localparam int SW = dmxr_pkg::SLOT_W;
  localparam int AW = dmxr_pkg::ADDR_W;

  // Configuration registers
  logic [31:0]   break_min;
  logic [31:0]   break_max;
  logic [7:0]    timeout_ticks;
  logic [AW-1:0] start_address;
  logic [CW-1:0] channel_count;

  // Frame state
  logic          receiving;
  logic [31:0]   edge_time;
  logic          edge_valid;
  logic [SW-1:0] slot_count;
  logic [7:0]    start_code;
  logic [7:0]    tick_count;
  logic [7:0]    window_store [dmxr_pkg::MAX_CHANNELS];

  // Readout
  logic [IW-1:0] rd_idx;
  logic [7:0]    rd_data;
  logic          rd_zero;
  logic          rd_last;

  logic [CW-1:0] active_n;
  logic [SW-1:0] first_slot;
  logic [SW-1:0] pos;
  logic          in_window;
  logic [31:0]   diff;
  logic          is_break;
  logic          frame_end;
  logic [8:0]    tick_inc;
  logic [SW-1:0] rd_slot;
  dmxr_pkg::op_t op_q;

  assign op_q = dmxr_pkg::op_t'(op);

  // Channel count saturated to the window size
  assign active_n = (channel_count > CW'(dmxr_pkg::MAX_CHANNELS)) ?
                    CW'(dmxr_pkg::MAX_CHANNELS) : channel_count;

  // Window placement of the current slot
  assign first_slot = SW'(start_address) + SW'(1);
  assign pos        = slot_count - first_slot;
  assign in_window  = (slot_count != '0) && (slot_count >= first_slot) &&
                      (pos < SW'(active_n));

  // Break pulse width, wrapping
  assign diff     = timestamp - edge_time;
  assign is_break = (diff > break_min) && (diff < break_max);

  assign frame_end = receiving && (slot_count == dmxr_pkg::LAST_SLOT);
  assign tick_inc  = {1'b0, tick_count} + 9'd1;

  assign stat.emit_req = (op_q == dmxr_pkg::OP_BYTE) && frame_end &&
                         (start_code == 8'd0) && (active_n != '0);
  assign stat.rd_last  = rd_last;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      break_min     <= dmxr_pkg::BREAK_MIN_RST;
      break_max     <= dmxr_pkg::BREAK_MAX_RST;
      timeout_ticks <= dmxr_pkg::TIMEOUT_RST;
      start_address <= dmxr_pkg::START_ADDR_RST;
      channel_count <= dmxr_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dmxr_pkg::REG_BREAK_MIN:     break_min     <= cfg_data;
        dmxr_pkg::REG_BREAK_MAX:     break_max     <= cfg_data;
        dmxr_pkg::REG_TIMEOUT:       timeout_ticks <= cfg_data[7:0];
        dmxr_pkg::REG_START_ADDRESS: start_address <= cfg_data[AW-1:0];
        dmxr_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Frame state update per item
  always_ff @(posedge clk) begin
    if (rst) begin
      receiving  <= 1'b0;
      edge_valid <= 1'b0;
      slot_count <= '0;
      tick_count <= '0;
      start_code <= '0;
    end else if (cmd.accept) begin
      unique case (op_q)
        dmxr_pkg::OP_FALL: begin
          if (!receiving) edge_valid <= 1'b1;
        end
        dmxr_pkg::OP_RISE: begin
          if (!receiving && edge_valid) begin
            edge_valid <= 1'b0;
            if (is_break) begin
              receiving  <= 1'b1;
              slot_count <= '0;
              tick_count <= '0;
            end
          end
        end
        dmxr_pkg::OP_BYTE: begin
          if (receiving) begin
            if (slot_count == '0) start_code <= data_byte;
            if (frame_end) begin
              receiving  <= 1'b0;
              slot_count <= '0;
              tick_count <= '0;
            end else begin
              slot_count <= slot_count + SW'(1);
            end
          end
        end
        dmxr_pkg::OP_TICK: begin
          if (receiving) begin
            if (tick_inc > {1'b0, timeout_ticks}) begin
              tick_count <= '0;
              receiving  <= 1'b0;
            end else begin
              tick_count <= tick_inc[7:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Falling edge timestamp, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept && (op_q == dmxr_pkg::OP_FALL) && !receiving) begin
      edge_time <= timestamp;
    end
  end

  // Window store write port
  always_ff @(posedge clk) begin
    if (cmd.accept && (op_q == dmxr_pkg::OP_BYTE) && receiving && in_window) begin
      window_store[pos[IW-1:0]] <= data_byte;
    end
  end

  // Readout index
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.rd_clear) begin
      rd_idx <= '0;
    end else if (cmd.rd_step) begin
      rd_idx <= rd_idx + IW'(1);
    end
  end

  // Slots beyond the end of the frame read as zero
  assign rd_slot = SW'(start_address) + SW'(1) + SW'(rd_idx);

  // Window store read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      rd_data <= window_store[rd_idx];
      rd_zero <= (rd_slot > dmxr_pkg::LAST_SLOT);
      rd_last <= ((CW'(rd_idx) + CW'(1)) == active_n);
    end
  end

  assign channel_value = rd_zero ? 8'd0 : rd_data;
  assign channel_index = 5'(rd_idx);
  assign last          = rd_last;

endmodule

[rtl/dmx512_frame_receiver.sv]
// DMX512 frame receiver top level: break detect, slot capture, window readout.
// Input items are taken in the cycle they are offered while no readout is running.
// The final slot byte of a frame with start code zero and a nonzero channel count
// starts a readout: each result takes a READ state, which loads the registered
// window store read, then a SHOW state, which presents it and holds through any output stall.
// Reset (rst, synchronous) clears control state and loads register defaults;
// the window store is not cleared.
`timescale 1ns / 1ps
module dmx512_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [31:0]                    timestamp,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     channel_value,
  output logic [4:0]                     channel_index,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dmxr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  dmxr_pkg::ctrl_cmd_t cmd;
  dmxr_pkg::dp_stat_t  stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  dmxr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dmxr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .timestamp     (timestamp),
    .data_byte     (data_byte),
    .channel_value (channel_value),
    .channel_index (channel_index),
    .last          (last)
  );

endmodule

[rtl/dmxr_checker.sv]
// Port-level checker for the DMX512 frame receiver, bound to the top level.
`timescale 1ns / 1ps
module dmxr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] channel_value,
  input logic [4:0] channel_index,
  input logic       last
);

  // Reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("result pending or input closed after reset");

  // A stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(channel_value) && $stable(channel_index) &&
       $stable(last)))
    else $error("stalled result changed");

  // No input taken during a readout
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input open while result pending");

  // Channels of a run come in order, with out_valid low between them
  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      (!out_valid ##1 (out_valid && (channel_index == $past(channel_index, 2) + 5'd1))))
    else $error("run channel out of order");

  // The run ends by reopening the input
  a_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (in_ready && !out_valid))
    else $error("input not reopened after last channel");

endmodule

bind dmx512_frame_receiver dmxr_checker u_dmxr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .channel_value (channel_value),
  .channel_index (channel_index),
  .last          (last)
);

[verif/dmx512_frame_receiver_checker.sv]
// Checker for the DMX512 frame receiver: predicts channel runs and compares them.
`timescale 1ns / 1ps
module dmx512_frame_receiver_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [31:0]                    timestamp,
  input  logic [7:0]                     data_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     channel_value,
  input  logic [4:0]                     channel_index,
  input  logic                           last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dmxr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import dmxr_pkg::*;

  localparam int unsigned FRAME_SLOTS = 513;

  typedef struct packed {
    logic [7:0] value;
    logic [4:0] index;
    logic       last;
  } channel_t;

  // Channels predicted but not yet seen on the output
  channel_t expected_channels[$];

  // Register copies
  logic [31:0]         brk_min;
  logic [31:0]         brk_max;
  int unsigned         timeout_lim;
  logic [ADDR_W-1:0]   start_addr;
  logic [CH_CNT_W-1:0] chan_count;

  // Frame tracking
  logic        rx_on;
  logic [31:0] fall_time;
  logic        fall_seen;
  int unsigned slot_no;
  logic [7:0]  code_byte;
  int unsigned tick_no;
  logic [7:0]  window_bytes [MAX_CHANNELS];

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int unsigned active_channels();
    return (chan_count > MAX_CHANNELS) ? MAX_CHANNELS : chan_count;
  endfunction

  task automatic clear_state();
    brk_min     = BREAK_MIN_RST;
    brk_max     = BREAK_MAX_RST;
    timeout_lim = 32'(TIMEOUT_RST);
    start_addr  = START_ADDR_RST;
    chan_count  = CHANNEL_COUNT_RST;
    rx_on       = 1'b0;
    fall_time   = '0;
    fall_seen   = 1'b0;
    slot_no     = 0;
    code_byte   = '0;
    tick_no     = 0;
    for (int i = 0; i < MAX_CHANNELS; i++) window_bytes[i] = '0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      REG_BREAK_MIN:     brk_min = data;
      REG_BREAK_MAX:     brk_max = data;
      REG_TIMEOUT:       timeout_lim = 32'(data[7:0]);
      REG_START_ADDRESS: start_addr = data[ADDR_W-1:0];
      REG_CHANNEL_COUNT: chan_count = data[CH_CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Queue the run of selected channels; slots past the frame end read 0
  task automatic queue_window();
    int unsigned n;
    channel_t want;
    n = active_channels();
    for (int unsigned i = 0; i < n; i++) begin
      want.value = (start_addr + 1 + i > LAST_SLOT) ? 8'h00 : window_bytes[i];
      want.index = 5'(i);
      want.last  = (i + 1 == n);
      expected_channels.push_back(want);
    end
  endtask

  // Advance the receiver state by one line event
  task automatic apply_line_event(input op_t kind, input logic [31:0] stamp,
                                  input logic [7:0] value);
    logic [31:0] low_time;
    int unsigned first;
    int unsigned pos;
    case (kind)
      OP_FALL: begin
        if (!rx_on) begin
          fall_time = stamp;
          fall_seen = 1'b1;
        end
      end
      OP_RISE: begin
        if (!rx_on && fall_seen) begin
          low_time = stamp - fall_time;
          if (low_time > brk_min && low_time < brk_max) begin
            rx_on   = 1'b1;
            slot_no = 0;
            tick_no = 0;
          end
          fall_seen = 1'b0;
        end
      end
      OP_BYTE: begin
        if (rx_on) begin
          if (slot_no == 0) begin
            code_byte = value;
          end else begin
            first = start_addr + 1;
            if (slot_no >= first) begin
              pos = slot_no - first;
              if (pos < active_channels()) window_bytes[pos] = value;
            end
          end
          slot_no++;
          if (slot_no >= FRAME_SLOTS) begin
            rx_on   = 1'b0;
            tick_no = 0;
            slot_no = 0;
            if (code_byte == 8'h00) queue_window();
          end
        end
      end
      default: begin
        // poll tick: abandon the frame once the allowance is used up
        if (rx_on) begin
          if (tick_no + 1 > timeout_lim) begin
            tick_no = 0;
            rx_on   = 1'b0;
          end else begin
            tick_no++;
          end
        end
      end
    endcase
  endtask

  // Watch all three channels at the rising edge
  always @(posedge clk) begin : watch
    channel_t seen;
    channel_t want;
    if (rst) begin
      clear_state();
      expected_channels.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) apply_line_event(op_t'(op), timestamp, data_byte);
      if (out_valid && out_ready) begin
        seen = '{channel_value, channel_index, last};
        if (expected_channels.size() == 0) begin
          note_mismatch($sformatf("unexpected channel value %0d index %0d last %0b",
                                  seen.value, seen.index, seen.last));
        end else begin
          want = expected_channels.pop_front();
          if (seen.value !== want.value || seen.index !== want.index ||
              seen.last !== want.last)
            note_mismatch($sformatf("channel got %0d/%0d/%0b want %0d/%0d/%0b",
                                    seen.value, seen.index, seen.last,
                                    want.value, want.index, want.last));
        end
      end
    end
    pending = expected_channels.size();
  end

endmodule

[verif/dmx512_frame_receiver_test.sv]
// Testbench top for the DMX512 frame receiver: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module dmx512_frame_receiver_test;
  import dmxr_pkg::*;

  localparam int unsigned FRAME_SLOTS = 513;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           op = OP_TICK;
  logic [31:0]          timestamp = '0;
  logic [7:0]           data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           channel_value;
  logic [4:0]           channel_index;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  int                   fail_count;
  int                   pending;

  // Register values as last written, used to build breaks and aborts
  logic [31:0] low_limit  = BREAK_MIN_RST;
  logic [31:0] high_limit = BREAK_MAX_RST;
  int unsigned tick_limit = 32'(TIMEOUT_RST);

  int burst_left = 0;

  always #5 clk = ~clk;

  dmx512_frame_receiver u_dut (.*);

  dmx512_frame_receiver_checker u_check (.*);

  // Hard stop
  initial begin
    #8_000_000;
    $display("dmx512_frame_receiver_test failed");
    $finish;
  end

  // Output side: one long hold on the first run, then mixed stall modes
  initial begin : rx_stall
    int       mode;
    int       mode_left;
    logic [7:0] pat;
    logic     long_hold_done;
    mode = 0;
    mode_left = 0;
    pat = '0;
    long_hold_done = 1'b0;
    @(negedge clk);
    forever begin
      if (!long_hold_done && out_valid) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
        pat       = 8'($urandom);
      end
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= pat[0];
          pat = {pat[0], pat[7:1]};
        end
      endcase
      mode_left--;
      @(negedge clk);
    end
  end

  // Offer one item in bursts with random gaps; called and returns at a falling edge
  task automatic send_item(input op_t kind, input logic [31:0] stamp, input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    op        <= kind;
    timestamp <= stamp;
    data_byte <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold input until every predicted channel has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Register write; bits above the register width carry junk
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    logic [31:0] keep;
    logic [31:0] word;
    case (idx)
      REG_BREAK_MIN, REG_BREAK_MAX: keep = '1;
      REG_TIMEOUT:                  keep = 32'h0000_00FF;
      REG_START_ADDRESS:            keep = 32'h0000_01FF;
      REG_CHANNEL_COUNT:            keep = 32'h0000_003F;
      default:                      keep = '0;
    endcase
    word = (val & keep) | ($urandom & ~keep);
    case (idx)
      REG_BREAK_MIN: low_limit = word;
      REG_BREAK_MAX: high_limit = word;
      REG_TIMEOUT:   tick_limit = 32'(word[7:0]);
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_config(input logic [31:0] bmin, input logic [31:0] bmax,
                              input logic [7:0] tmo, input logic [8:0] addr,
                              input logic [5:0] cnt);
    drain_results();
    set_reg(REG_BREAK_MIN, bmin);
    set_reg(REG_BREAK_MAX, bmax);
    set_reg(REG_TIMEOUT, 32'(tmo));
    set_reg(REG_START_ADDRESS, 32'(addr));
    set_reg(REG_CHANNEL_COUNT, 32'(cnt));
  endtask

  // Enough ticks to abandon any frame in progress
  task automatic end_frame_by_timeout();
    repeat (tick_limit + 1) send_item(OP_TICK, $urandom, 8'($urandom));
  endtask

  // Random ops plus pulses that sit exactly on the break limits
  task automatic send_noise(input int n);
    logic [31:0] t;
    repeat (n) send_item(op_t'($urandom_range(0, 3)), $urandom, 8'($urandom));
    if ($urandom_range(0, 1) == 1) begin
      t = $urandom;
      send_item(OP_FALL, t, 8'($urandom));
      send_item(OP_RISE, t + low_limit, 8'($urandom));
      t = $urandom;
      send_item(OP_FALL, t, 8'($urandom));
      send_item(OP_RISE, t + high_limit, 8'($urandom));
    end
  endtask

  // Break inside the window, then n_slots slot bytes with ticks and stray edges
  task automatic send_frame(input logic [7:0] code, input int unsigned n_slots);
    logic [63:0] span;
    logic [63:0] len;
    logic [31:0] t0;
    int unsigned ticks_left;
    span = {32'h0, high_limit} - {32'h0, low_limit};
    len  = {32'h0, low_limit} + 64'd1 + (64'($urandom) % (span - 64'd1));
    t0   = $urandom;
    send_item(OP_FALL, t0, 8'($urandom));
    send_item(OP_RISE, t0 + len[31:0], 8'($urandom));
    ticks_left = $urandom_range(0, tick_limit);
    for (int unsigned s = 0; s < n_slots; s++) begin
      if (ticks_left != 0 && $urandom_range(0, 31) == 0) begin
        send_item(OP_TICK, $urandom, 8'($urandom));
        ticks_left--;
      end
      if ($urandom_range(0, 127) == 0)
        send_item(op_t'($urandom_range(0, 1)), $urandom, 8'($urandom));
      send_item(OP_BYTE, $urandom, (s == 0) ? code : 8'($urandom));
    end
  endtask

  // One frame of random kind; the block is first forced back to waiting
  task automatic run_frame(input logic force_good);
    int k;
    k = force_good ? 0 : $urandom_range(0, 9);
    send_noise($urandom_range(0, 12));
    end_frame_by_timeout();
    if (k < 7) begin
      send_frame(8'h00, FRAME_SLOTS);
    end else if (k < 8) begin
      send_frame(8'($urandom_range(1, 255)), FRAME_SLOTS);
    end else begin
      send_frame(8'($urandom), $urandom_range(1, FRAME_SLOTS - 1));
      end_frame_by_timeout();
    end
    // keep offering items after a forced good frame so a held output stalls the input
    if (!force_good && $urandom_range(0, 3) == 0) drain_results();
  endtask

  task automatic run_frames(input int n);
    for (int i = 0; i < n; i++) run_frame(i == 0);
  endtask

  initial begin : stimulus
    logic [31:0] bmin;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: ignored events, break limits, wrap, edges while receiving
    send_item(OP_RISE, 32'd5, 8'hFF);             // rise with no fall before it
    send_item(OP_TICK, 32'hFFFF_FFFF, 8'h00);     // tick while waiting
    send_item(OP_BYTE, 32'h0000_0000, 8'hFF);     // byte while waiting
    send_item(OP_FALL, 32'd0, 8'h00);
    send_item(OP_FALL, 32'd100, 8'h00);           // later fall wins
    send_item(OP_RISE, 32'd108, 8'h00);           // exactly break_min: too short
    send_item(OP_RISE, 32'd120, 8'h00);           // fall already consumed
    send_item(OP_FALL, 32'd500, 8'h00);
    send_item(OP_RISE, 32'd1500, 8'h00);          // exactly break_max: too long
    send_item(OP_FALL, 32'hFFFF_FFF0, 8'h00);
    send_item(OP_RISE, 32'h0000_03D7, 8'h00);     // 999 across the timer wrap
    send_item(OP_FALL, 32'd0, 8'h00);             // edges while receiving
    send_item(OP_RISE, 32'd50, 8'h00);
    send_item(OP_BYTE, 32'd0, 8'h00);
    send_item(OP_BYTE, 32'd0, 8'hFF);
    send_item(OP_BYTE, 32'hFFFF_FFFF, 8'h80);
    end_frame_by_timeout();                       // abandon by timeout
    send_item(OP_FALL, 32'd1000, 8'h00);
    send_item(OP_RISE, 32'd1009, 8'h00);          // shortest break
    end_frame_by_timeout();

    // Reset settings; the long output hold lands here
    run_frames(2);

    // Widest break window, longest timeout, single channel
    write_config(32'h0000_0000, 32'hFFFF_FFFF, 8'd255, 9'd0, 6'd1);
    set_reg(REG_SPARE, $urandom);
    run_frames(2);

    // Window at the frame end, timeout on the first tick
    write_config(32'd20, 32'd40, 8'd0, 9'd511, 6'd32);
    run_frames(2);

    // No pulse can be a break
    write_config(32'hFFFF_FFFF, 32'h0000_0000, 8'd1, 9'd17, 6'd5);
    send_noise(24);
    drain_results();

    // Count above the window size, partly past the frame end
    write_config(32'd100, 32'd5000, 8'd50, 9'd495, 6'd63);
    run_frames(2);

    // Zero channels: frames complete silently
    write_config(32'd7, 32'd10, 8'd3, 9'd300, 6'd0);
    run_frames(2);

    // One-count break window, last full window before the frame end
    write_config(32'd0, 32'd2, 8'd200, 9'd480, 6'd32);
    run_frames(2);

    // Random settings
    repeat (3) begin
      bmin = $urandom_range(0, 5000);
      write_config(bmin, bmin + $urandom_range(2, 100000), 8'($urandom_range(1, 255)),
                   9'($urandom_range(0, 511)), 6'($urandom_range(1, 32)));
      run_frames(2);
    end

    drain_results();
    if (fail_count == 0) begin
      $display("dmx512_frame_receiver_test passed");
    end else begin
      $display("dmx512_frame_receiver_test failed");
    end
    $finish;
  end

endmodule
